### design/sttd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sttd_pkg
// Shared types and constants for the slot table with tombstone delete: the
// request and response payloads, status codes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package sttd_pkg;

  // Default table geometry.
  localparam int TABLE_DEPTH = 16;
  localparam int KEY_BITS    = 64;

  // Fixed payload widths.
  localparam int KEY_W   = 64;
  localparam int VALUE_W = 32;
  localparam int SLOT_W  = 4;

  // Request action codes.
  typedef enum logic {
    ACT_ADD    = 1'b0,
    ACT_DELETE = 1'b1
  } action_t;

  // Response status codes.
  typedef enum logic [1:0] {
    ST_ADDED   = 2'd0,
    ST_FULL    = 2'd1,
    ST_DELETED = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  // One request item.
  typedef struct packed {
    action_t                    action;
    logic [KEY_W-1:0]           key;
    logic signed [VALUE_W-1:0]  entry_value;
  } req_t;

  // One response item.
  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
  } rsp_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the accepted request and restart the scan
    logic scan;    // probe the next slot below the high-water mark
    logic commit;  // apply the update and load the response register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;  // a usable slot was found or the scan ran out
    logic out_free;   // the response register can take a new response
  } stat_t;

endpackage

### design/sttd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sttd_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module sttd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/sttd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sttd_ctrl
// Controller: accepts one request, runs the slot scan until the datapath
// reports a result, then commits once the response register is free.
// ----------------------------------------------------------------------------
module sttd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  output sttd_pkg::cmd_t  cmd,
  input  sttd_pkg::stat_t stat
);

  sttd_pkg::state_t state;
  sttd_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sttd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      sttd_pkg::S_IDLE: begin
        if (req_valid) begin
          state_next = sttd_pkg::S_SCAN;
        end
      end
      sttd_pkg::S_SCAN: begin
        if (stat.scan_done) begin
          state_next = sttd_pkg::S_COMMIT;
        end
      end
      sttd_pkg::S_COMMIT: begin
        if (stat.out_free) begin
          state_next = sttd_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = sttd_pkg::S_IDLE;
      end
    endcase
  end

  // Output logic. The scan holds once done so the found slot stays put.
  always_comb begin
    req_ready  = 1'b0;
    cmd.load   = 1'b0;
    cmd.scan   = 1'b0;
    cmd.commit = 1'b0;
    case (state)
      sttd_pkg::S_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
      end
      sttd_pkg::S_SCAN: begin
        cmd.scan = !stat.scan_done;
      end
      sttd_pkg::S_COMMIT: begin
        cmd.commit = stat.out_free;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

endmodule

### design/sttd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sttd_datapath
// Datapath: request registers, key and value memories, per-slot valid bits,
// the high-water count, the slot scan pointer and the response register.
// ----------------------------------------------------------------------------
module sttd_datapath #(
  parameter int TABLE_DEPTH = sttd_pkg::TABLE_DEPTH,
  parameter int KEY_BITS    = sttd_pkg::KEY_BITS
) (
  input  logic            clk,
  input  logic            rst,
  input  sttd_pkg::req_t  req,
  input  sttd_pkg::cmd_t  cmd,
  output sttd_pkg::stat_t stat,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output sttd_pkg::rsp_t  rsp
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = AW + sttd_pkg::SLOT_W;

  // Request registers.
  sttd_pkg::action_t                   act;
  logic [KEY_BITS-1:0]                 key_r;
  logic signed [sttd_pkg::VALUE_W-1:0] val_r;

  // Table state.
  logic [TABLE_DEPTH-1:0] valid;
  logic [CW-1:0]          hw;

  // Scan state.
  logic [CW-1:0] idx;
  logic [AW-1:0] probe_idx;
  logic          probe_valid;

  // Memory ports.
  logic [KEY_BITS-1:0] key_rd;
  logic                we;
  logic [AW-1:0]       waddr;
  logic [AW-1:0]       raddr;

  // Decisions.
  logic          idx_live;
  logic          hit;
  logic          full;
  logic [AW-1:0] rsp_idx;
  logic [EW-1:0] slot_ext;
  sttd_pkg::rsp_t rsp_next;

  // The next probe is still below the high-water mark.
  assign idx_live = idx < hw;
  assign full     = hw == CW'(TABLE_DEPTH);

  // A probed slot satisfies the request: free for add, matching for delete.
  always_comb begin
    if (act == sttd_pkg::ACT_ADD) begin
      hit = probe_valid && !valid[probe_idx];
    end else begin
      hit = probe_valid && valid[probe_idx] && (key_rd == key_r);
    end
  end

  assign stat.scan_done = hit || (!probe_valid && !idx_live);
  assign stat.out_free  = !rsp_valid || rsp_ready;

  // Memory writes on a successful add: freed slot first, else append.
  assign we    = cmd.commit && (act == sttd_pkg::ACT_ADD) && (hit || !full);
  assign waddr = hit ? probe_idx : hw[AW-1:0];

  // The key read follows the scan pointer while scanning and otherwise stays
  // on the probed slot, so a match found by the scan still holds at commit.
  assign raddr = cmd.scan ? idx[AW-1:0] : probe_idx;

  // Response built at commit.
  assign rsp_idx  = (act == sttd_pkg::ACT_ADD) ? waddr : probe_idx;
  assign slot_ext = {{sttd_pkg::SLOT_W{1'b0}}, rsp_idx};

  always_comb begin
    rsp_next.slot = slot_ext[sttd_pkg::SLOT_W-1:0];
    if (act == sttd_pkg::ACT_ADD) begin
      rsp_next.status = (hit || !full) ? sttd_pkg::ST_ADDED : sttd_pkg::ST_FULL;
      if (!hit && full) begin
        rsp_next.slot = '0;
      end
    end else begin
      rsp_next.status = hit ? sttd_pkg::ST_DELETED : sttd_pkg::ST_MISSING;
      if (!hit) begin
        rsp_next.slot = '0;
      end
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act   <= req.action;
      key_r <= req.key[KEY_BITS-1:0];
      val_r <= req.entry_value;
    end
  end

  // Scan pointer and probe stage, one slot per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_valid <= 1'b0;
      idx         <= '0;
    end else if (cmd.load) begin
      probe_valid <= 1'b0;
      idx         <= '0;
    end else if (cmd.scan) begin
      probe_valid <= idx_live;
      if (idx_live) begin
        idx <= idx + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      probe_idx <= idx[AW-1:0];
    end
  end

  // Valid bits and high-water count.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      hw    <= '0;
    end else if (cmd.commit) begin
      if (we) begin
        valid[waddr] <= 1'b1;
        if (!hit) begin
          hw <= hw + CW'(1);
        end
      end else if (act == sttd_pkg::ACT_DELETE && hit) begin
        valid[probe_idx] <= 1'b0;
      end
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp <= rsp_next;
    end
  end

  // Key memory, read by the scan.
  sttd_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (key_r),
    .raddr (raddr),
    .rdata (key_rd)
  );

  // Value memory, written alongside the key.
  sttd_ram #(
    .WIDTH (sttd_pkg::VALUE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_value_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (val_r),
    .raddr (waddr),
    .rdata ()
  );

endmodule

### design/slot_table_tombstone_delete_core.sv
`timescale 1ns / 1ps
// Response time is set by the key scan, which reads one slot per cycle from
//   the key memory up to the high-water mark.
// Throughput: one request in flight; the next is taken once the current
//   one is committed into the response register.
// Reset clears the valid bits, high-water count and handshakes; key and
//   value memory contents stay undefined and need no clearing pass.
// ----------------------------------------------------------------------------
// slot_table_tombstone_delete_core
// Key/value slot table with high-water allocation and tombstone delete.
// ----------------------------------------------------------------------------
module slot_table_tombstone_delete_core #(
  parameter int TABLE_DEPTH = sttd_pkg::TABLE_DEPTH,
  parameter int KEY_BITS    = sttd_pkg::KEY_BITS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  sttd_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output sttd_pkg::rsp_t rsp
);

  sttd_pkg::cmd_t  cmd;
  sttd_pkg::stat_t stat;

  // Controller.
  sttd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Datapath.
  sttd_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // Once a request is taken the block is busy in the following cycle.
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while previous request still in progress");

  // The controller commits only into a free response register.
  assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> stat.out_free)
    else $error("commit while response register is occupied");

  // At most one command is issued per cycle.
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.scan, cmd.commit}))
    else $error("conflicting datapath commands");

  // Full and missing responses report slot zero.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == sttd_pkg::ST_FULL || rsp.status == sttd_pkg::ST_MISSING)
    |-> rsp.slot == '0)
    else $error("nonzero slot on a failed request");

endmodule

### verif/sttd_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sttd_table_checker
// Watches both channels of the slot table. Every accepted request is applied
// to a private copy of the table to predict its response. Every accepted
// response is compared field by field with the oldest prediction. The
// mismatch count and the number of responses still owed go to the top.
// ----------------------------------------------------------------------------
module sttd_table_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_ready,
  input  sttd_pkg::req_t req,
  input  logic           rsp_valid,
  input  logic           rsp_ready,
  input  sttd_pkg::rsp_t rsp,
  output int unsigned    mismatch_count,
  output int unsigned    outstanding
);

  localparam logic [sttd_pkg::KEY_W-1:0] KEY_MASK =
    {sttd_pkg::KEY_W{1'b1}} >> (sttd_pkg::KEY_W - sttd_pkg::KEY_BITS);
  localparam int MAX_REPORTS = 10;

  // Private copy of the table contents.
  logic [sttd_pkg::KEY_W-1:0]   slot_key  [sttd_pkg::TABLE_DEPTH];
  logic [sttd_pkg::VALUE_W-1:0] slot_data [sttd_pkg::TABLE_DEPTH];
  logic                         slot_live [sttd_pkg::TABLE_DEPTH];
  int unsigned                  fill_mark;

  // Responses owed by the block, oldest first.
  sttd_pkg::rsp_t owed_rsp_q[$];
  int unsigned    err_total = 0;

  // Applies one request to the table copy and returns the response it earns.
  function automatic sttd_pkg::rsp_t apply_table_request(input sttd_pkg::req_t r);
    sttd_pkg::rsp_t             res;
    logic [sttd_pkg::KEY_W-1:0] k;
    int unsigned                i;
    bit                         placed;
    k      = r.key & KEY_MASK;
    placed = 1'b0;
    if (r.action == sttd_pkg::ACT_ADD) begin
      res.status = sttd_pkg::ST_FULL;
      res.slot   = '0;
      // Reuse the lowest tombstone below the fill mark first.
      for (i = 0; i < fill_mark && i < sttd_pkg::TABLE_DEPTH; i++) begin
        if (!placed && !slot_live[i]) begin
          slot_key[i]  = k;
          slot_data[i] = r.entry_value;
          slot_live[i] = 1'b1;
          res.status   = sttd_pkg::ST_ADDED;
          res.slot     = sttd_pkg::SLOT_W'(i);
          placed       = 1'b1;
        end
      end
      // Otherwise append at the fill mark if the table has room.
      if (!placed && fill_mark < sttd_pkg::TABLE_DEPTH) begin
        slot_key[fill_mark]  = k;
        slot_data[fill_mark] = r.entry_value;
        slot_live[fill_mark] = 1'b1;
        res.status           = sttd_pkg::ST_ADDED;
        res.slot             = sttd_pkg::SLOT_W'(fill_mark);
        fill_mark            = fill_mark + 1;
      end
    end else begin
      res.status = sttd_pkg::ST_MISSING;
      res.slot   = '0;
      // Only the lowest live slot holding the key is cleared.
      for (i = 0; i < fill_mark && i < sttd_pkg::TABLE_DEPTH; i++) begin
        if (!placed && slot_live[i] && slot_key[i] == k) begin
          slot_live[i] = 1'b0;
          res.status   = sttd_pkg::ST_DELETED;
          res.slot     = sttd_pkg::SLOT_W'(i);
          placed       = 1'b1;
        end
      end
    end
    return res;
  endfunction

  // Counts a failure and shows the first few of them.
  task automatic note_mismatch(input string what, input sttd_pkg::rsp_t want,
                               input sttd_pkg::rsp_t got);
    err_total = err_total + 1;
    if (err_total <= MAX_REPORTS) begin
      $display("[%0t] %s: expected status %0d slot %0d, got status %0d slot %0d",
               $realtime, what, want.status, want.slot, got.status, got.slot);
    end
  endtask

  // Check responses and record predictions on every clock edge.
  always @(posedge clk) begin
    sttd_pkg::rsp_t want;
    if (rst) begin
      for (int j = 0; j < sttd_pkg::TABLE_DEPTH; j++) begin
        slot_live[j] = 1'b0;
      end
      fill_mark = 0;
      owed_rsp_q.delete();
      outstanding    <= 0;
      mismatch_count <= err_total;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (owed_rsp_q.size() == 0) begin
          want = '0;
          note_mismatch("response with no request waiting", want, rsp);
        end else begin
          want = owed_rsp_q.pop_front();
          if (rsp.status !== want.status || rsp.slot !== want.slot) begin
            note_mismatch("response mismatch", want, rsp);
          end
        end
      end
      if (req_valid && req_ready) begin
        owed_rsp_q.push_back(apply_table_request(req));
      end
      outstanding    <= owed_rsp_q.size();
      mismatch_count <= err_total;
    end
  end

endmodule

### verif/slot_table_tombstone_delete_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_table_tombstone_delete_core_tb
// Drives add and delete requests into the slot table: a directed opening that
// covers tombstone reuse, duplicate keys, a full table and missing keys, then
// random traffic over a small key pool, under three idling patterns and one
// long response stall. Checking is done by sttd_table_checker.
// ----------------------------------------------------------------------------
module slot_table_tombstone_delete_core_tb;

  localparam int HOLD_CYCLES  = 400;
  localparam int POOL_SIZE    = 8;
  localparam int PHASE_ITEMS  = 283;
  localparam int SETTLE_WAIT  = sttd_pkg::TABLE_DEPTH + 8;

  logic           clk = 1'b0;
  logic           rst;
  logic           req_valid;
  logic           req_ready;
  sttd_pkg::req_t req;
  logic           rsp_valid;
  logic           rsp_ready;
  sttd_pkg::rsp_t rsp;

  int unsigned mismatch_count;
  int unsigned outstanding;

  // Idle percentages and the trigger for the long response stall.
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  logic        hold_go     = 1'b0;

  // Keys that random adds and deletes share, so deletes usually hit.
  logic [sttd_pkg::KEY_W-1:0] key_pool [POOL_SIZE];
  int unsigned                add_bias = 55;

  slot_table_tombstone_delete_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  sttd_table_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .req            (req),
    .rsp_valid      (rsp_valid),
    .rsp_ready      (rsp_ready),
    .rsp            (rsp),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  // Clock generation.
  initial begin
    forever #6 clk = ~clk;
  end

  // Run limit.
  initial begin
    #10_000_000;
    $display("slot_table_tombstone_delete_core_tb: errors");
    $finish;
  end

  // Response side: random ready, with one long stall on request.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    rsp_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_go && !hold_done) begin
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
        @(posedge clk);
      end
    end
  end

  function automatic logic [sttd_pkg::KEY_W-1:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic signed [sttd_pkg::VALUE_W-1:0] rand_value();
    logic signed [sttd_pkg::VALUE_W-1:0] v;
    case ($urandom_range(15))
      0:       v = 32'sh8000_0000;
      1:       v = 32'sh7fff_ffff;
      2:       v = 32'sh0000_0000;
      3:       v = -32'sd1;
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // Builds one random request: mostly pool keys, some stray keys as noise.
  function automatic sttd_pkg::req_t make_random_req();
    sttd_pkg::req_t r;
    int unsigned    roll;
    if ($urandom_range(99) < 3) begin
      key_pool[$urandom_range(POOL_SIZE - 1)] = rand_key();
    end
    roll          = $urandom_range(99);
    r.entry_value = rand_value();
    if (roll < 8) begin
      r.action = sttd_pkg::ACT_DELETE;
      r.key    = rand_key();
    end else if (roll < 13) begin
      r.action = sttd_pkg::ACT_ADD;
      r.key    = rand_key();
    end else begin
      r.action = ($urandom_range(99) < add_bias) ? sttd_pkg::ACT_ADD : sttd_pkg::ACT_DELETE;
      r.key    = key_pool[$urandom_range(POOL_SIZE - 1)];
    end
    return r;
  endfunction

  // Offers one request, idling first at the current rate, and returns at
  // the edge where it is accepted.
  task automatic send_req(input sttd_pkg::req_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  task automatic send_op(input sttd_pkg::action_t act,
                         input logic [sttd_pkg::KEY_W-1:0] k,
                         input logic signed [sttd_pkg::VALUE_W-1:0] v);
    sttd_pkg::req_t r;
    r.action      = act;
    r.key         = k;
    r.entry_value = v;
    send_req(r);
  endtask

  // Stops offering until every owed response has come back.
  task automatic drain();
    req_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic run_random(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        add_bias = $urandom_range(70, 40);
      end
      send_req(make_random_req());
    end
  endtask

  // Stimulus.
  initial begin
    logic [sttd_pkg::KEY_W-1:0] key_a;
    logic [sttd_pkg::KEY_W-1:0] key_b;
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      key_pool[i] = rand_key();
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed opening: empty table, extreme keys and values, duplicates,
    // tombstone reuse, a full table and a missing key.
    key_a = 64'haaaa_aaaa_aaaa_aaaa;
    key_b = 64'h5555_5555_5555_5555;
    send_op(sttd_pkg::ACT_DELETE, '0, 32'sh7fff_ffff);
    send_op(sttd_pkg::ACT_ADD, '0, 32'sh8000_0000);
    send_op(sttd_pkg::ACT_ADD, '1, 32'sh7fff_ffff);
    send_op(sttd_pkg::ACT_ADD, '0, 32'sh0000_0000);
    send_op(sttd_pkg::ACT_DELETE, '0, -32'sd1);
    send_op(sttd_pkg::ACT_ADD, key_a, -32'sd1);
    send_op(sttd_pkg::ACT_DELETE, '1, 32'sh8000_0000);
    send_op(sttd_pkg::ACT_ADD, key_b, 32'sh1234_5678);
    for (int i = 3; i < sttd_pkg::TABLE_DEPTH; i++) begin
      send_op(sttd_pkg::ACT_ADD, rand_key(), rand_value());
    end
    send_op(sttd_pkg::ACT_ADD, key_a, rand_value());
    send_op(sttd_pkg::ACT_DELETE, rand_key(), rand_value());
    send_op(sttd_pkg::ACT_DELETE, '0, rand_value());
    send_op(sttd_pkg::ACT_DELETE, key_b, rand_value());
    drain();

    // Random traffic, sender idling lightly and receiver heavily.
    tx_idle_pct = 22;
    rx_idle_pct <= 53;
    run_random(PHASE_ITEMS);
    drain();

    // The other way round.
    tx_idle_pct = 53;
    rx_idle_pct <= 22;
    run_random(PHASE_ITEMS);
    drain();

    // No idling, opening with a long response stall.
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    hold_go     <= 1'b1;
    run_random(PHASE_ITEMS + 1);
    drain();

    repeat (SETTLE_WAIT) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("slot_table_tombstone_delete_core_tb: clean");
    end else begin
      $display("slot_table_tombstone_delete_core_tb: errors");
    end
    $finish;
  end

endmodule
